// ===== rtl/oriented_gradient_integral_images_macros.svh =====
// Assertion macros shared by the RTL files
`ifndef ORIENTED_GRADIENT_INTEGRAL_IMAGES_MACROS_SVH
`define ORIENTED_GRADIENT_INTEGRAL_IMAGES_MACROS_SVH
// clocked implication, disabled while reset is asserted
`define OGI_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define OGI_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/ogii_pkg.sv =====
// Package: types, constants and tables for the oriented gradient integral images
package ogii_pkg;
	localparam int unsigned PIX_W = 8;
	localparam int unsigned LIN_W = 16;
	localparam int unsigned CW = 30;
	localparam int unsigned ZW = 32;
	localparam int unsigned MAG_W = 17;
	localparam int unsigned VAL_W = 37;
	localparam int unsigned DIM_W = 11;
	localparam int unsigned POS_W = 10;
	localparam int unsigned BIN_W = 4;
	localparam logic [MAG_W-1:0] MAG_MAX = 17'd92682;
	localparam logic [23:0] INV_GAIN_Q24 = 24'd10188014;
	localparam logic [DIM_W-1:0] HEIGHT_LIMIT = 11'd1024;

	// register indexes
	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// request from the sequencer to the gradient unit
	typedef struct packed {
		logic signed [LIN_W:0] dx;
		logic signed [LIN_W:0] dy;
	} grad_req_t;

	// result of the gradient unit
	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic [ZW-1:0] u;
	} grad_res_t;

	// gamma curve, millionths
	function automatic logic [19:0] gamma_micro(input logic [7:0] p);
		logic [19:0] t [256];
		t = '{
		0,304,607,911,1214,1518,1821,2125,2428,2732,3035,3347,3677,4025,4391,4777,
		5182,5605,6049,6512,6995,7499,8023,8568,9134,9721,10330,10960,11612,12286,12983,13702,
		14444,15209,15996,16807,17642,18500,19382,20289,21219,22174,23153,24158,25187,26241,
		27321,28426,29557,30713,31896,33105,34340,35601,36889,38204,39546,40915,42311,43735,
		45186,46665,48172,49707,51269,52861,54480,56128,57805,59511,61246,63010,64803,66626,
		68478,70360,72272,74214,76185,78187,80220,82283,84376,86500,88656,90842,93059,95307,
		97587,99899,102242,104616,107023,109462,111932,114435,116971,119538,122139,124772,
		127438,130136,132868,135633,138432,141263,144128,147027,149960,152926,155926,158961,
		162029,165132,168269,171441,174647,177888,181164,184475,187821,191202,194618,198069,
		201556,205079,208637,212231,215861,219526,223228,226966,230740,234551,238398,242281,
		246201,250158,254152,258183,262251,266356,270498,274677,278894,283149,287441,291771,
		296138,300544,304987,309469,313989,318547,323143,327778,332452,337164,341914,346704,
		351533,356400,361307,366253,371238,376262,381326,386429,391572,396755,401978,407240,
		412543,417885,423268,428690,434154,439657,445201,450786,456411,462077,467784,473531,
		479320,485150,491021,496933,502886,508881,514918,520996,527115,533276,539479,545724,
		552011,558340,564712,571125,577580,584078,590619,597202,603827,610496,617207,623960,
		630757,637597,644480,651406,658375,665387,672443,679542,686685,693872,701102,708376,
		715694,723055,730461,737910,745404,752942,760525,768151,775822,783538,791298,799103,
		806952,814847,822786,830770,838799,846873,854993,863157,871367,879622,887923,896269,
		904661,913099,921582,930111,938686,947307,955973,964686,973445,982251,991102,1000000};
		return t[p];
	endfunction

	// 16-bit linear values round(g * 65535 / 1e6), worked out at elaboration
	function automatic logic [256*LIN_W-1:0] lin_table();
		logic [256*LIN_W-1:0] tab;
		logic [39:0] prod;
		tab = '0;
		for (int i = 0; i < 256; i++) begin
			prod = {20'd0, gamma_micro(8'(i))} * 40'd65535 + 40'd500000;
			tab[i*LIN_W +: LIN_W] = LIN_W'(prod / 40'd1000000);
		end
		return tab;
	endfunction

	localparam logic [256*LIN_W-1:0] LIN_TAB = lin_table();

	// 16-bit linear value: table lookup
	function automatic logic [LIN_W-1:0] lin16(input logic [7:0] p);
		return LIN_TAB[12'(p) * LIN_W +: LIN_W];
	endfunction

	// atan(2^-i) in 2^-32 turns
	function automatic logic [ZW-1:0] atan_turn(input logic [4:0] i);
		logic [ZW-1:0] t [24];
		t = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81};
		return (i < 5'd24) ? t[i] : '0;
	endfunction
endpackage

// ===== rtl/ogii_if.sv =====
// Valid/ready channel interface
interface ogii_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ogii_cordic.sv =====
// Iterative CORDIC: one micro-rotation per cycle, then the magnitude scale
module ogii_cordic import ogii_pkg::*; #(
	parameter int unsigned CORDIC_STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input grad_req_t req,
	output logic done,
	output grad_res_t res
);
	localparam int unsigned SW = 5;
	localparam int unsigned NSTEP = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_ROT = 2'd1;
	localparam logic [1:0] S_MUL = 2'd2;
	localparam logic [1:0] S_OUT = 2'd3;

	logic [1:0] state_q;
	logic [SW-1:0] step_q;
	logic signed [CW-1:0] x_q, y_q;
	logic [ZW-1:0] z_q;
	logic [CW+23:0] prod_q;
	logic signed [CW-1:0] xs, ys, x_pos;
	logic signed [CW-1:0] x0, y0;
	logic [MAG_W-1:0] mag_c;
	logic [CW+23:0] rounded;

	// prescale and fold into the right half-plane
	assign x0 = CW'(req.dx) <<< 8;
	assign y0 = CW'(req.dy) <<< 8;
	// arithmetic shift is the floor shift
	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign x_pos = x_q[CW-1] ? '0 : x_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) begin
					state_q <= S_ROT;
					step_q <= '0;
				end
				S_ROT: begin
					if (32'(step_q) == NSTEP - 1) state_q <= S_MUL;
					step_q <= step_q + 1'b1;
				end
				S_MUL: state_q <= S_OUT;
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			if (x0 < 0) begin
				x_q <= -x0;
				y_q <= -y0;
				z_q <= 32'h8000_0000;
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end
		end else if (state_q == S_ROT) begin
			if (!y_q[CW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_turn(step_q);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_turn(step_q);
			end
		end else if (state_q == S_MUL) begin
			prod_q <= (CW+24)'($unsigned(x_pos)) * (CW+24)'(INV_GAIN_Q24);
		end
	end

	assign rounded = (prod_q + (CW+24)'(33'h8000_0000)) >> 32;
	assign mag_c = (rounded > (CW+24)'(MAG_MAX)) ? MAG_MAX : MAG_W'(rounded);
	assign done = (state_q == S_OUT);
	assign res.mag = mag_c;
	assign res.u = z_q + 32'h8000_0000;

	`include "oriented_gradient_integral_images_macros.svh"
	`OGI_ASSERT_IMP(a_step_range, state_q == S_ROT, 32'(step_q) < NSTEP, "step overrun")
	`OGI_ASSERT_NXT(a_out_one, state_q == S_OUT, state_q == S_IDLE, "result held twice")
	`OGI_ASSERT_IMP(a_mag_sat, done, res.mag <= MAG_MAX, "magnitude above limit")
endmodule

// ===== rtl/oriented_gradient_integral_images.sv =====
// Top level: oriented gradient integral images, sequenced per pixel
// Each accepted pixel takes a fixed sequence: the accept step (left and upper
// row-store reads), a step to read the right neighbour, a step to start the
// shared iterative CORDIC, the CORDIC run itself, a step to split the
// magnitude over two bins, then per bin a column memory read, then update and
// result, for NUM_BINS results, 2*NUM_BINS on the last row. A pixel of row 0
// sends nothing and goes straight back to idle. The input is not ready during
// the sequence. After reset the column integral memory is cleared one entry a
// cycle, all NUM_BINS*MAX_WIDTH entries, before the first pixel is accepted.
// Results leave through an output register, so a stalled sink holds the
// sequence in the emit step only.
module oriented_gradient_integral_images import ogii_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 1024,
	parameter int unsigned NUM_BINS = 12,
	parameter int unsigned CORDIC_STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	ogii_if.sink in_ch,
	ogii_if.source out_ch,
	input logic cfg_we,
	input logic cfg_index,
	input logic [DIM_W-1:0] cfg_data
);
	localparam int unsigned XW = $clog2(MAX_WIDTH);
	localparam int unsigned BW = $clog2(NUM_BINS);
	localparam int unsigned MW = $clog2(NUM_BINS * MAX_WIDTH);
	localparam int unsigned DEPTH = NUM_BINS * MAX_WIDTH;
	localparam int unsigned BMUL = NUM_BINS * 256;
	localparam int unsigned RSW = MAG_W + XW;

	localparam logic [2:0] S_CLR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RD = 3'd2;
	localparam logic [2:0] S_CORD = 3'd3;
	localparam logic [2:0] S_SPLIT = 3'd4;
	localparam logic [2:0] S_MRD = 3'd5;
	localparam logic [2:0] S_EMIT = 3'd6;
	localparam logic [2:0] S_GRAD = 3'd7;

	typedef struct packed {
		logic [BIN_W-1:0] bin_index;
		logic [POS_W-1:0] column;
		logic [POS_W-1:0] row;
		logic [VAL_W-1:0] integral_value;
		logic last;
	} res_t;
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic frame_start;
	} pix_t;

	logic [2:0] state_q;
	logic [DIM_W-1:0] width_q, height_q;
	logic [DIM_W-1:0] w_c, h_c;
	logic [DIM_W-1:0] col_q, row_q;
	logic [DIM_W-1:0] x_q, y_q;
	logic [PIX_W-1:0] p_q;
	logic [MW-1:0] clr_q;
	logic [BW-1:0] bin_q;
	logic flush_q;
	logic grad_q;
	logic [MAG_W-1:0] w0_q, w1_q;
	logic [BW-1:0] b0_q, b1_q;
	logic [RSW-1:0] rsum_q [NUM_BINS];
	logic [PIX_W-1:0] pstore [2*MAX_WIDTH];
	logic [PIX_W-1:0] pl_q, pr_q, pu_q;
	logic [VAL_W-1:0] cstore [DEPTH];
	logic [VAL_W-1:0] crd_q;
	logic ovalid_q;
	res_t ores_q;
	pix_t in_d;
	logic cord_start, cord_done;
	grad_req_t greq;
	grad_res_t gres;
	logic [DIM_W-1:0] x_n, y_n;
	logic [XW-1:0] xi;
	logic [MW-1:0] caddr;
	logic [ZW+12:0] tprod;
	logic [12:0] t_c;
	logic [BW:0] b0_c, b1_c;
	logic [MAG_W+7:0] mw1;
	logic [RSW-1:0] radd, rnew;
	logic [VAL_W-1:0] vnew;
	logic emit_go;

	assign in_d = in_ch.data;

	// clamped sizes
	always_comb begin
		w_c = width_q;
		if (w_c < 11'd3) w_c = 11'd3;
		if (32'(w_c) > MAX_WIDTH) w_c = DIM_W'(MAX_WIDTH);
		h_c = height_q;
		if (h_c < 11'd3) h_c = 11'd3;
		if (h_c > HEIGHT_LIMIT) h_c = HEIGHT_LIMIT;
	end

	// position of the incoming pixel
	always_comb begin
		x_n = in_d.frame_start ? '0 : col_q;
		y_n = in_d.frame_start ? '0 : row_q;
		if (x_n >= w_c) begin
			x_n = '0;
			y_n = y_n + 1'b1;
		end
		if (y_n >= h_c) y_n = '0;
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'd640;
			height_q <= 11'd480;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH: width_q <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign xi = XW'(x_q);
	assign caddr = MW'(bin_q * MAX_WIDTH) + MW'(xi);
	assign in_ch.ready = (state_q == S_IDLE);
	assign cord_start = (state_q == S_GRAD);
	assign greq.dx = grad_q ? (LIN_W+1)'(lin16(pr_q)) - (LIN_W+1)'(lin16(pl_q)) : '0;
	assign greq.dy = grad_q ? (LIN_W+1)'(lin16(p_q)) - (LIN_W+1)'(lin16(pu_q)) : '0;

	ogii_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cord_start), .req(greq),
		.done(cord_done), .res(gres)
	);

	// angle to bin and fraction
	assign tprod = (ZW+13)'(gres.u) * (ZW+13)'(BMUL);
	assign t_c = tprod[ZW+12:ZW];
	always_comb begin
		b0_c = (BW+1)'(t_c >> 8);
		if (b0_c >= (BW+1)'(NUM_BINS)) b0_c = '0;
		b1_c = b0_c + 1'b1;
		if (b1_c >= (BW+1)'(NUM_BINS)) b1_c = '0;
	end
	assign mw1 = (MAG_W+8)'(gres.mag) * (MAG_W+8)'(t_c[7:0]);

	// per-bin update
	always_comb begin
		radd = '0;
		if (grad_q && bin_q == b0_q) radd = radd + RSW'(w0_q);
		if (grad_q && bin_q == b1_q) radd = radd + RSW'(w1_q);
		rnew = ((xi == '0) ? '0 : rsum_q[bin_q]) + radd;
		vnew = ((y_q == 11'd1) ? '0 : crd_q) + VAL_W'(rnew);
	end
	assign emit_go = (state_q == S_EMIT) && (!ovalid_q || out_ch.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			col_q <= '0;
			row_q <= '0;
			bin_q <= '0;
			flush_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			ovalid_q <= emit_go || (ovalid_q && !out_ch.ready);
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == DEPTH - 1) state_q <= S_IDLE;
				end
				S_IDLE: if (in_ch.valid) begin
					if (x_n + 1'b1 >= w_c) begin
						col_q <= '0;
						row_q <= (y_n + 1'b1 >= h_c) ? '0 : y_n + 1'b1;
					end else begin
						col_q <= x_n + 1'b1;
						row_q <= y_n;
					end
					state_q <= (y_n == '0) ? S_IDLE : S_RD;
				end
				S_RD: state_q <= S_GRAD;
				S_GRAD: state_q <= S_CORD;
				S_CORD: if (cord_done) begin
					state_q <= S_SPLIT;
				end
				S_SPLIT: begin
					bin_q <= '0;
					flush_q <= 1'b0;
					state_q <= S_MRD;
				end
				S_MRD: state_q <= S_EMIT;
				S_EMIT: if (emit_go) begin
					if (32'(bin_q) == NUM_BINS - 1) begin
						bin_q <= '0;
						if (!flush_q && y_q == h_c - 1'b1) begin
							flush_q <= 1'b1;
							state_q <= S_MRD;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						bin_q <= bin_q + 1'b1;
						state_q <= S_MRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers and memories
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid) begin
			x_q <= x_n;
			y_q <= y_n;
			p_q <= in_d.pixel;
			grad_q <= (y_n >= 11'd2) && (x_n >= 11'd1) && (x_n + 1'b1 < w_c);
			// upper pixel is read before the new one overwrites it
			pu_q <= pstore[{y_n[0], XW'(x_n)}];
			pstore[{y_n[0], XW'(x_n)}] <= in_d.pixel;
			pl_q <= pstore[{~y_n[0], XW'(x_n) - 1'b1}];
		end
		if (state_q == S_RD) begin
			pr_q <= pstore[{~y_q[0], xi + 1'b1}];
		end
		if (state_q == S_CLR) cstore[clr_q] <= '0;
		if (state_q == S_MRD) crd_q <= cstore[caddr];
		if (state_q == S_SPLIT) begin
			b0_q <= b0_c[BW-1:0];
			b1_q <= b1_c[BW-1:0];
			w1_q <= MAG_W'(mw1 >> 8);
			w0_q <= gres.mag - MAG_W'(mw1 >> 8);
		end
		if (emit_go) begin
			ores_q.bin_index <= BIN_W'(bin_q);
			ores_q.column <= POS_W'(x_q);
			if (flush_q) begin
				ores_q.row <= POS_W'(y_q);
				ores_q.integral_value <= crd_q;
				ores_q.last <= (32'(bin_q) == NUM_BINS - 1);
			end else begin
				ores_q.row <= POS_W'(y_q - 1'b1);
				ores_q.integral_value <= vnew;
				ores_q.last <= (32'(bin_q) == NUM_BINS - 1) && (y_q != h_c - 1'b1);
				rsum_q[bin_q] <= rnew;
				cstore[caddr] <= vnew;
			end
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.data = ores_q;

	`include "oriented_gradient_integral_images_macros.svh"
	`OGI_ASSERT_IMP(a_no_take_busy, state_q != S_IDLE, !in_ch.ready, "input taken while busy")
	`OGI_ASSERT_IMP(a_bin_range, state_q == S_EMIT, 32'(bin_q) < NUM_BINS, "bin out of range")
	`OGI_ASSERT_NXT(a_hold, out_ch.valid && !out_ch.ready, out_ch.valid, "result dropped")
endmodule

// ===== dv/oriented_gradient_integral_images_tb.sv =====
// Testbench: oriented gradient integral images against a cycle-free integral predictor
module oriented_gradient_integral_images_tb;
	import ogii_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic frame_start;
	} pixel_t;

	typedef struct packed {
		logic [BIN_W-1:0] bin_index;
		logic [POS_W-1:0] column;
		logic [POS_W-1:0] row;
		logic [VAL_W-1:0] integral_value;
		logic last;
	} integral_t;

	localparam int BINS = 12;
	localparam int ROW_SPAN = 1024;
	localparam int STEPS = 16;
	localparam int SETTLE = 40;
	localparam int IDLE_LIMIT = 60000;
	localparam longint VAL_MASK = (64'd1 << VAL_W) - 1;

	// gamma curve, millionths
	localparam int unsigned GAMMA_PPM [256] = '{
		0,304,607,911,1214,1518,1821,2125,2428,2732,3035,3347,3677,4025,4391,4777,
		5182,5605,6049,6512,6995,7499,8023,8568,9134,9721,10330,10960,11612,12286,12983,
		13702,14444,15209,15996,16807,17642,18500,19382,20289,21219,22174,23153,24158,
		25187,26241,27321,28426,29557,30713,31896,33105,34340,35601,36889,38204,39546,
		40915,42311,43735,45186,46665,48172,49707,51269,52861,54480,56128,57805,59511,
		61246,63010,64803,66626,68478,70360,72272,74214,76185,78187,80220,82283,84376,
		86500,88656,90842,93059,95307,97587,99899,102242,104616,107023,109462,111932,
		114435,116971,119538,122139,124772,127438,130136,132868,135633,138432,141263,
		144128,147027,149960,152926,155926,158961,162029,165132,168269,171441,174647,
		177888,181164,184475,187821,191202,194618,198069,201556,205079,208637,212231,
		215861,219526,223228,226966,230740,234551,238398,242281,246201,250158,254152,
		258183,262251,266356,270498,274677,278894,283149,287441,291771,296138,300544,
		304987,309469,313989,318547,323143,327778,332452,337164,341914,346704,351533,
		356400,361307,366253,371238,376262,381326,386429,391572,396755,401978,407240,
		412543,417885,423268,428690,434154,439657,445201,450786,456411,462077,467784,
		473531,479320,485150,491021,496933,502886,508881,514918,520996,527115,533276,
		539479,545724,552011,558340,564712,571125,577580,584078,590619,597202,603827,
		610496,617207,623960,630757,637597,644480,651406,658375,665387,672443,679542,
		686685,693872,701102,708376,715694,723055,730461,737910,745404,752942,760525,
		768151,775822,783538,791298,799103,806952,814847,822786,830770,838799,846873,
		854993,863157,871367,879622,887923,896269,904661,913099,921582,930111,938686,
		947307,955973,964686,973445,982251,991102,1000000};

	// arctangent steps in 2^-32 turns
	localparam int unsigned ATAN_TURN [STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [DIM_W-1:0] cfg_data;

	ogii_if #(.T(pixel_t)) pix_ch ();
	ogii_if #(.T(integral_t)) int_ch ();

	oriented_gradient_integral_images dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(pix_ch.sink),
		.out_ch(int_ch.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic [7:0] row_pixels [2*ROW_SPAN];
	longint col_integral [BINS*ROW_SPAN];
	longint row_sum [BINS];
	int unsigned col_pos, row_pos;
	logic [DIM_W-1:0] width_reg, height_reg;
	integral_t pending_integrals [$];

	int mismatches;
	int pixels_sent, integrals_seen, frames_sent;
	int burst_left;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint linear16(input logic [7:0] p);
		return (longint'(GAMMA_PPM[p]) * 65535 + 500000) / 1000000;
	endfunction

	// CORDIC magnitude and angle, split over two neighbouring bins
	function automatic void split_gradient(input longint dx, input longint dy,
		output int b0, output int b1, output longint w0, output longint w1);
		longint gx, gy, nx, mag, t;
		logic [31:0] z, u;
		int alpha;
		gx = dx * 256;
		gy = dy * 256;
		z = '0;
		b0 = 0;
		b1 = 1;
		w0 = 0;
		w1 = 0;
		if (gx < 0) begin
			gx = -gx;
			gy = -gy;
			z = 32'h8000_0000;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (gy >= 0) begin
				nx = gx + (gy >>> i);
				gy = gy - (gx >>> i);
				z = z + ATAN_TURN[i];
			end else begin
				nx = gx - (gy >>> i);
				gy = gy + (gx >>> i);
				z = z - ATAN_TURN[i];
			end
			gx = nx;
		end
		if (gx < 0) gx = 0;
		mag = (gx * longint'(INV_GAIN_Q24) + 64'sh8000_0000) >>> 32;
		if (mag > longint'(MAG_MAX)) mag = longint'(MAG_MAX);
		if (mag == 0) return;
		u = z + 32'h8000_0000;
		t = (longint'({32'd0, u}) * (BINS * 256)) >>> 32;
		b0 = int'(t >>> 8);
		alpha = int'(t & 255);
		if (b0 >= BINS) b0 = 0;
		b1 = (b0 + 1 >= BINS) ? 0 : b0 + 1;
		w1 = (mag * alpha) >>> 8;
		w0 = mag - w1;
	endfunction

	// integral values caused by one accepted pixel
	task automatic predict_integrals(input pixel_t item);
		int unsigned w, h, x, y, r, cur, prv;
		int b0, b1;
		longint w0, w1, v;
		longint g [BINS];
		integral_t e;
		integral_t batch [$];
		w = width_reg;
		h = height_reg;
		if (w < 3) w = 3;
		if (w > ROW_SPAN) w = ROW_SPAN;
		if (h < 3) h = 3;
		if (h > 1024) h = 1024;
		if (item.frame_start) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h) row_pos = 0;
		x = col_pos;
		y = row_pos;
		cur = y[0] ? ROW_SPAN : 0;
		prv = y[0] ? 0 : ROW_SPAN;
		if (y >= 1) begin
			r = y - 1;
			foreach (g[b]) g[b] = 0;
			// gradient is zero on the border
			if (r >= 1 && x >= 1 && x + 1 < w) begin
				split_gradient(linear16(row_pixels[prv+x+1]) - linear16(row_pixels[prv+x-1]),
					linear16(item.pixel) - linear16(row_pixels[cur+x]), b0, b1, w0, w1);
				g[b0] += w0;
				g[b1] += w1;
			end
			if (x == 0) foreach (row_sum[b]) row_sum[b] = 0;
			for (int b = 0; b < BINS; b++) begin
				row_sum[b] += g[b];
				v = ((r == 0) ? 0 : col_integral[b*ROW_SPAN+x]) + row_sum[b];
				v &= VAL_MASK;
				col_integral[b*ROW_SPAN+x] = v;
				e = '{bin_index: BIN_W'(b), column: POS_W'(x), row: POS_W'(r),
					integral_value: VAL_W'(v), last: 1'b0};
				batch.push_back(e);
			end
			// last row flushed with a zero gradient row
			if (y == h - 1)
				for (int b = 0; b < BINS; b++) begin
					e = '{bin_index: BIN_W'(b), column: POS_W'(x), row: POS_W'(y),
						integral_value: VAL_W'(col_integral[b*ROW_SPAN+x]), last: 1'b0};
					batch.push_back(e);
				end
			batch[batch.size()-1].last = 1'b1;
			foreach (batch[k]) pending_integrals.push_back(batch[k]);
		end
		row_pixels[cur+x] = item.pixel;
		col_pos = x + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = y + 1;
			if (row_pos >= h) row_pos = 0;
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
			integrals_seen);
		mismatches++;
	endtask

	// transfer monitor: predict on pixels in, compare integrals out
	always @(posedge clk) begin
		integral_t got, want;
		if (arst_n) begin
			if (pix_ch.valid && pix_ch.ready) predict_integrals(pix_ch.data);
			if (int_ch.valid && int_ch.ready) begin
				got = int_ch.data;
				integrals_seen++;
				if (pending_integrals.size() == 0) begin
					report_mismatch("unexpected result, bin", got.bin_index, -1);
				end else begin
					want = pending_integrals.pop_front();
					if (got.bin_index !== want.bin_index)
						report_mismatch("bin_index", got.bin_index, want.bin_index);
					if (got.column !== want.column)
						report_mismatch("column", got.column, want.column);
					if (got.row !== want.row)
						report_mismatch("row", got.row, want.row);
					if (got.integral_value !== want.integral_value)
						report_mismatch("integral_value", got.integral_value,
							want.integral_value);
					if (got.last !== want.last)
						report_mismatch("last", got.last, want.last);
				end
			end
		end
	end

	// receiver stall pattern from a periodically redrawn random mode
	always @(posedge clk) begin
		int unsigned cyc;
		int unsigned mode;
		cyc++;
		if (cyc % 64 == 0) mode = $urandom_range(3);
		case (mode)
			0: int_ch.ready <= 1'b1;
			1: int_ch.ready <= 1'($urandom_range(1));
			2: int_ch.ready <= (cyc % 4 == 0);
			default: int_ch.ready <= ($urandom_range(7) != 0);
		endcase
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		int idle;
		if ((pix_ch.valid && pix_ch.ready) || (int_ch.valid && int_ch.ready)) idle = 0;
		else idle++;
		if (idle >= IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic release_input();
		pix_ch.valid <= 1'b0;
	endtask

	// one pixel transfer, with sender bursts and gaps
	task automatic send_pixel(input logic [7:0] p, input logic fs);
		pixel_t item;
		item.pixel = p;
		item.frame_start = fs;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(4) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 8);
			if ($urandom_range(3) != 0) begin
				pix_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		pix_ch.data <= item;
		pix_ch.valid <= 1'b1;
		do @(posedge clk); while (!pix_ch.ready);
		pixels_sent++;
	endtask

	// wait for every expected integral, then for the block to settle
	task automatic drain();
		release_input();
		while (pending_integrals.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// one register write; the caller drops the write enable afterwards
	task automatic write_reg(input logic idx, input logic [DIM_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == REG_WIDTH) width_reg = val;
		else height_reg = val;
	endtask

	task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		drain();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		cfg_we <= 1'b0;
	endtask

	// pixel content: random, ramp, or black/white
	function automatic logic [7:0] pick_pixel(input int style, input int x, input int y,
		input int sx, input int sy, input int base);
		case (style)
			0: return 8'($urandom_range(255));
			1: return 8'(base + sx * x + sy * y + $urandom_range(3));
			default: return $urandom_range(1) ? 8'd255 : 8'd0;
		endcase
	endfunction

	task automatic send_frame(input int w, input int h, input int n, input int style);
		int sx, sy, base;
		sx = $urandom_range(40) - 20;
		sy = $urandom_range(40) - 20;
		base = $urandom_range(255);
		for (int k = 0; k < n; k++)
			send_pixel(pick_pixel(style, k % w, k / w, sx, sy, base), k == 0);
		frames_sent++;
	endtask

	// smallest image: extremes, checkerboard, frame wrap without a start mark, restart mid-frame
	task automatic test_directed();
		logic [7:0] board [9];
		set_geometry(11'd3, 11'd3);
		for (int k = 0; k < 9; k++) board[k] = ((k % 2) == 0) ? 8'd255 : 8'd0;
		for (int k = 0; k < 9; k++) send_pixel(board[k], k == 0);
		// next frame follows by counter wrap alone
		for (int k = 0; k < 9; k++) send_pixel(8'(k * 31), 1'b0);
		// restart in the middle of a frame
		send_pixel(8'd255, 1'b1);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd128, 1'b0);
		send_pixel(8'd1, 1'b0);
		send_pixel(8'd254, 1'b1);
	endtask

	// registers below range are clamped to the smallest image
	task automatic test_clamped_geometry();
		set_geometry(11'd0, 11'd1);
		send_frame(3, 3, 9, 0);
		set_geometry(11'd1, 11'd0);
		send_frame(3, 3, 12, 2);
	endtask

	// random small images, mostly whole frames, some cut short, some running into the next frame
	task automatic test_random_frames();
		int w, h, n, start;
		start = pixels_sent;
		while (pixels_sent - start < 410) begin
			w = $urandom_range(3, 10);
			h = $urandom_range(3, 6);
			set_geometry(DIM_W'(w), DIM_W'(h));
			n = ($urandom_range(4) == 0) ? $urandom_range(1, w * h) : w * h;
			if ($urandom_range(5) == 0) n = n + w * h;
			send_frame(w, h, n, $urandom_range(2));
			// the sender waits for every result once mid-stream
			if (frames_sent == 8) drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = '0;
		pix_ch.valid = 1'b0;
		pix_ch.data = '0;
		int_ch.ready = 1'b0;
		width_reg = 11'd640;
		height_reg = 11'd480;
		col_pos = 0;
		row_pos = 0;
		foreach (row_pixels[k]) row_pixels[k] = '0;
		foreach (col_integral[k]) col_integral[k] = 0;
		foreach (row_sum[k]) row_sum[k] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_clamped_geometry();
		test_random_frames();
		drain();
		$display("covered %0d pixel transfers in %0d frames, %0d integral results checked",
			pixels_sent, frames_sent, integrals_seen);
		$display("geometry from clamped 3x3 up to 10x6, ramps, noise and extremes");
		if (mismatches == 0 && pending_integrals.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

// ===== oriented_gradient_integral_images.f =====
+incdir+rtl
rtl/ogii_pkg.sv
rtl/ogii_if.sv
rtl/ogii_cordic.sv
rtl/oriented_gradient_integral_images.sv
dv/oriented_gradient_integral_images_tb.sv
